// ===== rtl/core/ubalu_pkg.sv =====
// Shared types for the unsigned binary ALU: command codes and the
// sequencer-to-datapath control bundle. No dependencies.
package ubalu_pkg;

  // Operation codes carried on in_command
  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_t;

  // Sequencer controls for the shift-register datapath
  typedef struct packed {
    logic load;   // capture operands of an accepted beat
    logic step;   // advance the datapath one iteration
    logic last;   // final iteration of the current operation
    cmd_t cmd;    // operation in progress
  } ctrl_t;

endpackage

// ===== rtl/core/unsigned_binary_alu_unit.sv =====
// Top level of the unsigned binary ALU: add, subtract, multiply, divide.
// Instantiates ubalu_ctrl and ubalu_datapath; uses ubalu_pkg.
//
//   channel | ports                                   | handshake
//   --------+-----------------------------------------+------------------------
//   input   | in_command, in_operand_a, in_operand_b  | start while busy is low
//   result  | out_result_value, out_remainder_value,  | out_valid, one cycle
//           | out_negative, out_divide_by_zero        |
//
// Multiply and divide run the shift-add / restoring-divide loop of the
// datapath, one bit per cycle. busy is high from the accepting edge through
// the cycle of out_valid and drops in the cycle after it.
// Synchronous active-low reset clears the sequencer; datapath registers are
// reloaded on every accepted beat. The receiver cannot stall the result.
module unsigned_binary_alu_unit #(
  parameter int WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_operand_a,
  input  logic [31:0] in_operand_b,
  output logic        out_valid,
  output logic [63:0] out_result_value,
  output logic [31:0] out_remainder_value,
  output logic        out_negative,
  output logic        out_divide_by_zero
);

  ubalu_pkg::ctrl_t ctrl;

  ubalu_ctrl #(
    .WIDTH (WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .busy       (busy),
    .out_valid  (out_valid),
    .ctrl       (ctrl)
  );

  ubalu_datapath #(
    .WIDTH (WIDTH)
  ) u_datapath (
    .clk                 (clk),
    .ctrl                (ctrl),
    .in_command          (in_command),
    .in_operand_a        (in_operand_a),
    .in_operand_b        (in_operand_b),
    .out_result_value    (out_result_value),
    .out_remainder_value (out_remainder_value),
    .out_negative        (out_negative),
    .out_divide_by_zero  (out_divide_by_zero)
  );

`ifndef ASSERT_OFF
  // An accepted beat keeps the unit busy on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted beat");

  // The result strobe lasts one cycle and only while busy
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (busy ##1 !out_valid))
    else $error("result strobe longer than one cycle");

  // A negative difference carries no remainder and no divide flag
  a_neg_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_negative) |-> (out_remainder_value == 32'd0 && !out_divide_by_zero))
    else $error("negative result with divide fields set");

  // Division by zero returns zero quotient and remainder
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_divide_by_zero) |->
      (out_result_value == 64'd0 && out_remainder_value == 32'd0))
    else $error("divide by zero with nonzero result");
`endif

endmodule

// ===== rtl/core/ubalu_ctrl.sv =====
// Sequencer for the unsigned binary ALU: accepts a command, counts the
// iterations of the datapath and strobes the result. Uses ubalu_pkg.
module ubalu_ctrl #(
  parameter int WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        in_command,
  output logic              busy,
  output logic              out_valid,
  output ubalu_pkg::ctrl_t  ctrl
);

  localparam int CNT_W = $clog2(WIDTH);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  ubalu_pkg::cmd_t     cmd_r, cmd_nxt;
  ubalu_pkg::cmd_t     in_cmd;
  logic                accept;
  logic                last;

  assign in_cmd = ubalu_pkg::cmd_t'(in_command);
  assign accept = start && (state_r == ST_IDLE);
  assign last   = (cnt_r == '0);

  // Walk idle -> run -> done, loading the iteration count per command
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd_nxt   = cmd_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_RUN;
          cmd_nxt   = in_cmd;
          case (in_cmd)
            ubalu_pkg::CMD_ADD: cnt_nxt = '0;
            ubalu_pkg::CMD_SUB: cnt_nxt = CNT_W'(1);
            default:            cnt_nxt = CNT_W'(WIDTH - 1);
          endcase
        end
      end
      ST_RUN: begin
        if (last) begin
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      cmd_r   <= ubalu_pkg::CMD_ADD;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      cmd_r   <= cmd_nxt;
    end
  end

  // Drive handshake and datapath controls
  assign busy       = (state_r != ST_IDLE);
  assign out_valid  = (state_r == ST_DONE);
  assign ctrl.load  = accept;
  assign ctrl.step  = (state_r == ST_RUN);
  assign ctrl.last  = last;
  assign ctrl.cmd   = cmd_r;

endmodule

// ===== rtl/core/ubalu_datapath.sv =====
// Shift-register datapath of the unsigned binary ALU: hi/lo shift pair,
// operand-b register (addend, multiplicand, divisor) and one shared adder/subtractor. Uses ubalu_pkg.
module ubalu_datapath #(
  parameter int WIDTH = 32
) (
  input  logic              clk,
  input  ubalu_pkg::ctrl_t  ctrl,
  input  logic [1:0]        in_command,
  input  logic [31:0]       in_operand_a,
  input  logic [31:0]       in_operand_b,
  output logic [63:0]       out_result_value,
  output logic [31:0]       out_remainder_value,
  output logic              out_negative,
  output logic              out_divide_by_zero
);

  logic [WIDTH-1:0] hi_r, hi_nxt;
  logic [WIDTH-1:0] lo_r, lo_nxt;
  logic [WIDTH-1:0] b_r, b_nxt;
  logic             neg_r, neg_nxt;
  logic             dz_r, dz_nxt;

  logic [WIDTH+1:0] add_x, add_y, add_s;
  logic             add_sub;
  logic             borrow;
  logic             is_div;

  // Operand selection for the shared adder
  always_comb begin
    add_x   = {2'b00, lo_r};
    add_y   = {2'b00, b_r};
    add_sub = 1'b0;
    case (ctrl.cmd)
      ubalu_pkg::CMD_ADD: begin
        add_sub = 1'b0;
      end
      ubalu_pkg::CMD_SUB: begin
        add_sub = 1'b1;
        if (ctrl.last) begin
          add_x = {2'b00, b_r};
          add_y = {2'b00, lo_r};
        end
      end
      ubalu_pkg::CMD_MUL: begin
        add_x = {2'b00, hi_r};
        add_y = lo_r[0] ? {2'b00, b_r} : '0;
      end
      default: begin
        add_x   = {1'b0, hi_r, lo_r[WIDTH-1]};
        add_sub = 1'b1;
      end
    endcase
  end

  assign add_s  = add_x + (add_sub ? ~add_y : add_y) + {{(WIDTH+1){1'b0}}, add_sub};
  assign borrow = add_s[WIDTH+1];

  // Load operands on a beat, then advance one iteration per step
  always_comb begin
    hi_nxt  = hi_r;
    lo_nxt  = lo_r;
    b_nxt   = b_r;
    neg_nxt = neg_r;
    dz_nxt  = dz_r;
    if (ctrl.load) begin
      hi_nxt  = '0;
      lo_nxt  = in_operand_a[WIDTH-1:0];
      b_nxt   = in_operand_b[WIDTH-1:0];
      neg_nxt = 1'b0;
      dz_nxt  = (ubalu_pkg::cmd_t'(in_command) == ubalu_pkg::CMD_DIV) &&
                (in_operand_b[WIDTH-1:0] == '0);
    end else if (ctrl.step) begin
      case (ctrl.cmd)
        ubalu_pkg::CMD_ADD: begin
          lo_nxt = add_s[WIDTH-1:0];
          hi_nxt = {{(WIDTH-1){1'b0}}, add_s[WIDTH]};
        end
        ubalu_pkg::CMD_SUB: begin
          if (!ctrl.last) begin
            // a - b into hi, remember the borrow
            hi_nxt  = add_s[WIDTH-1:0];
            neg_nxt = borrow;
          end else begin
            // take b - a when a - b went negative
            lo_nxt = neg_r ? add_s[WIDTH-1:0] : hi_r;
            hi_nxt = '0;
          end
        end
        ubalu_pkg::CMD_MUL: begin
          hi_nxt = add_s[WIDTH:1];
          lo_nxt = {add_s[0], lo_r[WIDTH-1:1]};
        end
        default: begin
          // restoring divide: keep the partial on borrow, shift in quotient bit
          hi_nxt = borrow ? {hi_r[WIDTH-2:0], lo_r[WIDTH-1]} : add_s[WIDTH-1:0];
          lo_nxt = {lo_r[WIDTH-2:0], ~borrow};
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    hi_r  <= hi_nxt;
    lo_r  <= lo_nxt;
    b_r   <= b_nxt;
    neg_r <= neg_nxt;
    dz_r  <= dz_nxt;
  end

  // Assemble the result fields from the shift pair
  assign is_div = (ctrl.cmd == ubalu_pkg::CMD_DIV);

  always_comb begin
    if (dz_r) begin
      out_result_value    = '0;
      out_remainder_value = '0;
    end else if (is_div) begin
      out_result_value    = 64'(lo_r);
      out_remainder_value = 32'(hi_r);
    end else begin
      out_result_value    = 64'({hi_r, lo_r});
      out_remainder_value = '0;
    end
  end

  assign out_negative       = neg_r;
  assign out_divide_by_zero = dz_r;

endmodule
